// ===== rtl/core/http_chunked_stream_decoder_top_macros.svh =====
// assertion macros for the chunked stream decoder
`ifndef HTTP_CHUNKED_STREAM_DECODER_TOP_MACROS_SVH
`define HTTP_CHUNKED_STREAM_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define HCSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hcsd assertion failed");
`define HCSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hcsd assertion failed");
`else
`define HCSD_ASSERT_IMP(lbl, ante, cons)
`define HCSD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/hcsd_pkg.sv =====
`default_nettype none
package hcsd_pkg;

  localparam int SIZE_BITS       = 32;
  localparam int LINE_COUNT_BITS = 14;
  localparam int CFG_W           = 14;
  localparam int CFG_IDX_W       = 2;
  localparam int CNT_CMP_W       = (LINE_COUNT_BITS > CFG_W ? LINE_COUNT_BITS : CFG_W) + 1;

  localparam logic [CNT_CMP_W-1:0] COUNT_MAX = CNT_CMP_W'((64'd1 << LINE_COUNT_BITS) - 64'd1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE_LINE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRAIL_LINE = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     MAX_SIZE_LINE_RST  = CFG_W'(1024);
  localparam logic [CFG_W-1:0]     MAX_TRAIL_LINE_RST = CFG_W'(8192);

  // parser phases
  localparam logic [3:0] PH_SIZE     = 4'd0;
  localparam logic [3:0] PH_SIZE_EXT = 4'd1;
  localparam logic [3:0] PH_SIZE_LF  = 4'd2;
  localparam logic [3:0] PH_DATA     = 4'd3;
  localparam logic [3:0] PH_DATA_CR  = 4'd4;
  localparam logic [3:0] PH_DATA_LF  = 4'd5;
  localparam logic [3:0] PH_TRAIL    = 4'd6;
  localparam logic [3:0] PH_TRAIL_LF = 4'd7;
  localparam logic [3:0] PH_DONE     = 4'd8;
  localparam logic [3:0] PH_ERROR    = 4'd9;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_TRAILER = 2'd2;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_SIZE_LONG  = 3'd1;
  localparam logic [2:0] ERR_BAD_HEX    = 3'd2;
  localparam logic [2:0] ERR_OVERFLOW   = 3'd3;
  localparam logic [2:0] ERR_NO_CRLF    = 3'd4;
  localparam logic [2:0] ERR_TRAIL_LONG = 3'd5;
  localparam logic [2:0] ERR_BARE_CR    = 3'd6;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  out_kind;
    logic        chunk_end;
    logic        size_ready;
    logic [31:0] chunk_length;
    logic        done_res;
    logic [2:0]  error_code;
  } out_t;

  typedef struct packed {
    logic [3:0]                 phase;
    logic [SIZE_BITS-1:0]       size_accum;
    logic [SIZE_BITS-1:0]       bytes_left;
    logic [LINE_COUNT_BITS-1:0] line_count;
    logic                       digit_seen;
    logic                       trail_space_seen;
    logic                       line_nonempty;
  } state_t;

  typedef struct packed {
    logic [CFG_W-1:0] max_size_line_len;
    logic [CFG_W-1:0] max_trailer_line_len;
  } cfg_t;

  // returns {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hcsd_step.sv =====
`default_nettype none
module hcsd_step (
  input  hcsd_pkg::state_t state_i,
  input  hcsd_pkg::in_t    in_i,
  input  hcsd_pkg::cfg_t   cfg_i,
  output hcsd_pkg::state_t state_o,
  output hcsd_pkg::out_t   res_o
);

  logic [7:0]                          c;
  logic [4:0]                          hex;
  logic [hcsd_pkg::CFG_W-1:0]          limit;
  logic [hcsd_pkg::CNT_CMP_W-1:0]      cnt_next;
  logic                                too_long;
  logic [hcsd_pkg::LINE_COUNT_BITS-1:0] cnt_sat;
  logic [hcsd_pkg::SIZE_BITS-1:0]      left_next;
  logic [2:0]                          err;
  hcsd_pkg::state_t                    s;
  hcsd_pkg::out_t                      r;

  assign c   = in_i.in_byte;
  assign hex = hcsd_pkg::hex_decode(c);

  // trailer phases count against the trailer limit
  assign limit = (state_i.phase == hcsd_pkg::PH_TRAIL) ? cfg_i.max_trailer_line_len
                                                       : cfg_i.max_size_line_len;
  assign cnt_next = hcsd_pkg::CNT_CMP_W'(state_i.line_count) + hcsd_pkg::CNT_CMP_W'(1);
  assign too_long = cnt_next > hcsd_pkg::CNT_CMP_W'(limit);
  assign cnt_sat  = (cnt_next > hcsd_pkg::COUNT_MAX)
                  ? hcsd_pkg::LINE_COUNT_BITS'(hcsd_pkg::COUNT_MAX)
                  : cnt_next[hcsd_pkg::LINE_COUNT_BITS-1:0];
  assign left_next = state_i.bytes_left - hcsd_pkg::SIZE_BITS'(1);

  always_comb begin
    s   = state_i;
    r   = '0;
    err = hcsd_pkg::ERR_NONE;
    if (in_i.restart) begin
      s       = '0;
      s.phase = hcsd_pkg::PH_SIZE;
    end else begin
      case (state_i.phase)
        hcsd_pkg::PH_SIZE: begin
          if (c == hcsd_pkg::CH_CR) begin
            s.phase = hcsd_pkg::PH_SIZE_LF;
          end else if (too_long) begin
            err = hcsd_pkg::ERR_SIZE_LONG;
          end else begin
            s.line_count = cnt_sat;
            if (c == hcsd_pkg::CH_SEMI) begin
              s.phase = hcsd_pkg::PH_SIZE_EXT;
            end else if (c == hcsd_pkg::CH_SPACE || c == hcsd_pkg::CH_TAB) begin
              if (state_i.digit_seen) begin
                s.trail_space_seen = 1'b1;
              end
            end else if (!hex[4] || state_i.trail_space_seen) begin
              err = hcsd_pkg::ERR_BAD_HEX;
            end else if (state_i.size_accum[hcsd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
              err = hcsd_pkg::ERR_OVERFLOW;
            end else begin
              s.size_accum = {state_i.size_accum[hcsd_pkg::SIZE_BITS-5:0], hex[3:0]};
              s.digit_seen = 1'b1;
            end
          end
        end
        hcsd_pkg::PH_SIZE_EXT: begin
          if (c == hcsd_pkg::CH_CR) begin
            s.phase = hcsd_pkg::PH_SIZE_LF;
          end else if (too_long) begin
            err = hcsd_pkg::ERR_SIZE_LONG;
          end else begin
            s.line_count = cnt_sat;
          end
        end
        hcsd_pkg::PH_SIZE_LF: begin
          if (c != hcsd_pkg::CH_LF) begin
            err = hcsd_pkg::ERR_BARE_CR;
          end else if (!state_i.digit_seen) begin
            err = hcsd_pkg::ERR_BAD_HEX;
          end else begin
            r.size_ready       = 1'b1;
            r.chunk_length     = 32'(state_i.size_accum);
            s.bytes_left       = state_i.size_accum;
            s.phase            = (state_i.size_accum == '0) ? hcsd_pkg::PH_TRAIL
                                                            : hcsd_pkg::PH_DATA;
            s.size_accum       = '0;
            s.line_count       = '0;
            s.digit_seen       = 1'b0;
            s.trail_space_seen = 1'b0;
            s.line_nonempty    = 1'b0;
          end
        end
        hcsd_pkg::PH_DATA: begin
          r.out_byte   = c;
          r.out_kind   = hcsd_pkg::KIND_PAYLOAD;
          s.bytes_left = left_next;
          if (left_next == '0) begin
            r.chunk_end = 1'b1;
            s.phase     = hcsd_pkg::PH_DATA_CR;
          end
        end
        hcsd_pkg::PH_DATA_CR: begin
          if (c == hcsd_pkg::CH_CR) begin
            s.phase = hcsd_pkg::PH_DATA_LF;
          end else begin
            err = hcsd_pkg::ERR_NO_CRLF;
          end
        end
        hcsd_pkg::PH_DATA_LF: begin
          if (c == hcsd_pkg::CH_LF) begin
            s.phase            = hcsd_pkg::PH_SIZE;
            s.line_count       = '0;
            s.digit_seen       = 1'b0;
            s.trail_space_seen = 1'b0;
            s.line_nonempty    = 1'b0;
          end else begin
            err = hcsd_pkg::ERR_NO_CRLF;
          end
        end
        hcsd_pkg::PH_TRAIL: begin
          if (c == hcsd_pkg::CH_CR) begin
            if (state_i.line_nonempty) begin
              r.out_byte = c;
              r.out_kind = hcsd_pkg::KIND_TRAILER;
            end
            s.phase = hcsd_pkg::PH_TRAIL_LF;
          end else if (too_long) begin
            err = hcsd_pkg::ERR_TRAIL_LONG;
          end else begin
            s.line_count    = cnt_sat;
            r.out_byte      = c;
            r.out_kind      = hcsd_pkg::KIND_TRAILER;
            s.line_nonempty = 1'b1;
          end
        end
        hcsd_pkg::PH_TRAIL_LF: begin
          if (c != hcsd_pkg::CH_LF) begin
            err = hcsd_pkg::ERR_BARE_CR;
          end else if (state_i.line_nonempty) begin
            r.out_byte         = c;
            r.out_kind         = hcsd_pkg::KIND_TRAILER;
            s.phase            = hcsd_pkg::PH_TRAIL;
            s.line_count       = '0;
            s.digit_seen       = 1'b0;
            s.trail_space_seen = 1'b0;
            s.line_nonempty    = 1'b0;
          end else begin
            r.done_res = 1'b1;
            s.phase    = hcsd_pkg::PH_DONE;
          end
        end
        default: begin
          // done or error: halted until restart
        end
      endcase
      if (err != hcsd_pkg::ERR_NONE) begin
        r            = '0;
        r.error_code = err;
        s.phase      = hcsd_pkg::PH_ERROR;
      end
    end
  end

  assign state_o = s;
  assign res_o   = r;

endmodule
`default_nettype wire

// ===== rtl/core/http_chunked_stream_decoder_top.sv =====
`default_nettype none
// Chunked transfer decoder taking one encoded byte per beat and giving one result beat for
// each input beat. A new byte can be accepted every cycle while results are not stalled.
// A taken byte waits in the input register, then moves into the result register with the
// parser state updated as it moves, and its result leaves from there. A stalled result
// register holds the byte in the input register, and input is refused only while both are
// full. Configuration writes are always taken and apply to every byte that leaves the input
// register after the write, so write them only while no byte is in flight.
`include "http_chunked_stream_decoder_top_macros.svh"
module http_chunked_stream_decoder_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output      logic                               in_ready_o,
  input  wire hcsd_pkg::in_t                      in_data_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_ready_i,
  output      hcsd_pkg::out_t                     out_data_o,
  input  wire logic                               cfg_valid_i,
  output      logic                               cfg_ready_o,
  input  wire logic [hcsd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [hcsd_pkg::CFG_W-1:0]         cfg_data_i
);

  logic             stg_vld_q;
  hcsd_pkg::in_t    stg_q;
  logic             out_vld_q;
  hcsd_pkg::out_t   out_q;
  hcsd_pkg::state_t state_q;
  hcsd_pkg::state_t state_d;
  hcsd_pkg::out_t   res_d;
  hcsd_pkg::cfg_t   cfg_q;
  logic             adv;

  // the staged beat moves on when the result register is free or being emptied
  assign adv         = stg_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !stg_vld_q || adv;
  assign cfg_ready_o = 1'b1;

  hcsd_step u_step (
    .state_i (state_q),
    .in_i    (stg_q),
    .cfg_i   (cfg_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
      cfg_q.max_size_line_len    <= hcsd_pkg::MAX_SIZE_LINE_RST;
      cfg_q.max_trailer_line_len <= hcsd_pkg::MAX_TRAIL_LINE_RST;
    end else begin
      if (in_ready_o) begin
        stg_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          hcsd_pkg::CFG_MAX_SIZE_LINE:  cfg_q.max_size_line_len    <= cfg_data_i;
          hcsd_pkg::CFG_MAX_TRAIL_LINE: cfg_q.max_trailer_line_len <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stg_q <= in_data_i;
    end
    if (adv) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `HCSD_ASSERT_NXT(a_err_halts,
                   adv && res_d.error_code != hcsd_pkg::ERR_NONE,
                   state_q.phase == hcsd_pkg::PH_ERROR)
  `HCSD_ASSERT_IMP(a_err_clean,
                   out_vld_q && out_q.error_code != hcsd_pkg::ERR_NONE,
                   out_q.out_kind == hcsd_pkg::KIND_NONE && !out_q.size_ready && !out_q.done_res)
  `HCSD_ASSERT_IMP(a_end_payload,
                   out_vld_q && out_q.chunk_end,
                   out_q.out_kind == hcsd_pkg::KIND_PAYLOAD)
  `HCSD_ASSERT_IMP(a_stall_held, !in_ready_o, stg_vld_q && out_vld_q && !out_ready_i)

endmodule
`default_nettype wire

// ===== bench/hcsd_decode_checker.sv =====
`timescale 1ns / 100ps
module hcsd_decode_checker
  import hcsd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_t                  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_t                 out_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   mismatches_o,
  output int                   pending_o
);

  logic [CFG_W-1:0]           size_limit;
  logic [CFG_W-1:0]           trail_limit;
  logic [3:0]                 parse_phase;
  logic [SIZE_BITS-1:0]       size_acc;
  logic [SIZE_BITS-1:0]       chunk_left;
  logic [LINE_COUNT_BITS-1:0] line_len;
  logic                       saw_digit;
  logic                       saw_gap;
  logic                       line_has_data;
  out_t                       decoded_q[$];
  int                         results_seen;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    // keep the log short when the block is badly off
    if (mismatches_o < 60) begin
      $display("%0t: result %0d %s: got %0h, want %0h", $time, results_seen, what, got, want);
    end
    mismatches_o++;
  endtask

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    if (c >= "0" && c <= "9") begin
      return {1'b1, c[3:0]};
    end
    if (folded >= "a" && folded <= "f") begin
      return {1'b1, 4'(folded[3:0] + 4'd9)};
    end
    return 5'd0;
  endfunction

  task automatic clear_line();
    line_len      = '0;
    saw_digit     = 1'b0;
    saw_gap       = 1'b0;
    line_has_data = 1'b0;
  endtask

  // counts one line byte, true once the line runs past its limit
  function automatic logic line_over(input logic [CFG_W-1:0] limit);
    int unsigned next;
    next = line_len + 1;
    if (next > limit) begin
      return 1'b1;
    end
    line_len = LINE_COUNT_BITS'((next > COUNT_MAX) ? COUNT_MAX : next);
    return 1'b0;
  endfunction

  task automatic decode_step(input in_t beat, output out_t res);
    logic [7:0] c;
    logic [4:0] dig;
    logic [2:0] err;
    c   = beat.in_byte;
    res = '0;
    err = ERR_NONE;
    if (beat.restart) begin
      parse_phase = PH_SIZE;
      size_acc    = '0;
      chunk_left  = '0;
      clear_line();
    end else begin
      case (parse_phase)
        PH_SIZE: begin
          dig = hex_digit(c);
          if (c == CH_CR) begin
            parse_phase = PH_SIZE_LF;
          end else if (line_over(size_limit)) begin
            err = ERR_SIZE_LONG;
          end else if (c == CH_SEMI) begin
            parse_phase = PH_SIZE_EXT;
          end else if (c == CH_SPACE || c == CH_TAB) begin
            saw_gap = saw_gap | saw_digit;
          end else if (!dig[4] || saw_gap) begin
            err = ERR_BAD_HEX;
          end else if (size_acc[SIZE_BITS-1 -: 4] != 4'd0) begin
            err = ERR_OVERFLOW;
          end else begin
            size_acc  = {size_acc[SIZE_BITS-5:0], dig[3:0]};
            saw_digit = 1'b1;
          end
        end
        PH_SIZE_EXT: begin
          if (c == CH_CR) begin
            parse_phase = PH_SIZE_LF;
          end else if (line_over(size_limit)) begin
            err = ERR_SIZE_LONG;
          end
        end
        PH_SIZE_LF: begin
          if (c != CH_LF) begin
            err = ERR_BARE_CR;
          end else if (!saw_digit) begin
            err = ERR_BAD_HEX;
          end else begin
            res.size_ready   = 1'b1;
            res.chunk_length = size_acc;
            chunk_left       = size_acc;
            parse_phase      = (size_acc == '0) ? PH_TRAIL : PH_DATA;
            size_acc         = '0;
            clear_line();
          end
        end
        PH_DATA: begin
          res.out_byte = c;
          res.out_kind = KIND_PAYLOAD;
          chunk_left   = chunk_left - 1'b1;
          if (chunk_left == '0) begin
            res.chunk_end = 1'b1;
            parse_phase   = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          if (c == CH_CR) begin
            parse_phase = PH_DATA_LF;
          end else begin
            err = ERR_NO_CRLF;
          end
        end
        PH_DATA_LF: begin
          if (c == CH_LF) begin
            parse_phase = PH_SIZE;
            clear_line();
          end else begin
            err = ERR_NO_CRLF;
          end
        end
        PH_TRAIL: begin
          if (c == CH_CR) begin
            // the empty line keeps its line end to itself
            if (line_has_data) begin
              res.out_byte = c;
              res.out_kind = KIND_TRAILER;
            end
            parse_phase = PH_TRAIL_LF;
          end else if (line_over(trail_limit)) begin
            err = ERR_TRAIL_LONG;
          end else begin
            res.out_byte  = c;
            res.out_kind  = KIND_TRAILER;
            line_has_data = 1'b1;
          end
        end
        PH_TRAIL_LF: begin
          if (c != CH_LF) begin
            err = ERR_BARE_CR;
          end else if (line_has_data) begin
            res.out_byte = c;
            res.out_kind = KIND_TRAILER;
            parse_phase  = PH_TRAIL;
            clear_line();
          end else begin
            res.done_res = 1'b1;
            parse_phase  = PH_DONE;
          end
        end
        default: begin
        end
      endcase
      if (err != ERR_NONE) begin
        res            = '0;
        res.error_code = err;
        parse_phase    = PH_ERROR;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    out_t want;
    out_t fresh;
    if (!rst_ni) begin
      size_limit  = MAX_SIZE_LINE_RST;
      trail_limit = MAX_TRAIL_LINE_RST;
      parse_phase = PH_SIZE;
      size_acc    = '0;
      chunk_left  = '0;
      clear_line();
      decoded_q.delete();
      results_seen = 0;
      mismatches_o = 0;
      pending_o   <= 0;
    end else begin
      // the result of a byte taken at this edge cannot leave at the same edge
      if (out_valid_i && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("beat with nothing expected", 32'(out_data_i.out_byte), 32'd0);
        end else begin
          want = decoded_q.pop_front();
          if (out_data_i.out_byte !== want.out_byte)
            report_mismatch("out_byte", 32'(out_data_i.out_byte), 32'(want.out_byte));
          if (out_data_i.out_kind !== want.out_kind)
            report_mismatch("out_kind", 32'(out_data_i.out_kind), 32'(want.out_kind));
          if (out_data_i.chunk_end !== want.chunk_end)
            report_mismatch("chunk_end", 32'(out_data_i.chunk_end), 32'(want.chunk_end));
          if (out_data_i.size_ready !== want.size_ready)
            report_mismatch("size_ready", 32'(out_data_i.size_ready), 32'(want.size_ready));
          if (out_data_i.chunk_length !== want.chunk_length)
            report_mismatch("chunk_length", out_data_i.chunk_length, want.chunk_length);
          if (out_data_i.done_res !== want.done_res)
            report_mismatch("done_res", 32'(out_data_i.done_res), 32'(want.done_res));
          if (out_data_i.error_code !== want.error_code)
            report_mismatch("error_code", 32'(out_data_i.error_code), 32'(want.error_code));
        end
        results_seen++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MAX_SIZE_LINE:  size_limit  = cfg_data_i;
          CFG_MAX_TRAIL_LINE: trail_limit = cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        decode_step(in_data_i, fresh);
        decoded_q.push_back(fresh);
      end
      pending_o <= decoded_q.size();
    end
  end

endmodule

// ===== bench/http_chunked_stream_decoder_top_tb.sv =====
`timescale 1ns / 100ps
module http_chunked_stream_decoder_top_tb;
  import hcsd_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 300;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid;
  logic                 in_ready;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   mismatches;
  int                   pending;
  int                   idle_cycles;
  logic                 quiet;
  logic                 hold_req;
  logic                 hold_done;
  in_t                  stream_q[$];
  logic [7:0]           msg_q[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  http_chunked_stream_decoder_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  hcsd_decode_checker decode_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("http_chunked_stream_decoder_top verification failed");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int unsigned span;
    out_ready = 1'b0;
    hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        span       = LONG_HOLD;
        hold_done  = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        span       = $urandom_range(1, 11);
      end else begin
        out_ready <= 1'b1;
        span       = quiet ? 1 : $urandom_range(1, 40);
      end
      repeat (span) @(posedge clk_i);
    end
  end

  function automatic logic [7:0] any_but_cr();
    logic [7:0] b;
    do begin
      b = 8'($urandom);
    end while (b == CH_CR);
    return b;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic lower);
    if (nib < 4'd10) begin
      return 8'h30 + nib;
    end
    return (lower ? 8'h61 : 8'h41) + nib - 8'd10;
  endfunction

  task automatic add_byte(input logic [7:0] b);
    msg_q.push_back(b);
  endtask

  task automatic add_text(input string s);
    for (int k = 0; k < s.len(); k++) begin
      add_byte(s[k]);
    end
  endtask

  task automatic add_crlf();
    add_byte(CH_CR);
    add_byte(CH_LF);
  endtask

  task automatic add_line(input string s);
    add_text(s);
    add_crlf();
  endtask

  task automatic flush_msg();
    in_t item;
    foreach (msg_q[k]) begin
      item.in_byte = msg_q[k];
      item.restart = 1'b0;
      stream_q.push_back(item);
    end
    msg_q.delete();
  endtask

  task automatic restart_stream();
    in_t item;
    flush_msg();
    item.in_byte = 8'($urandom);
    item.restart = 1'b1;
    stream_q.push_back(item);
  endtask

  task automatic add_size_line(input logic [31:0] v);
    int   ndig;
    logic lower;
    lower = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    end
    if ($urandom_range(0, 3) == 0) begin
      add_byte("0");
    end
    ndig = 1;
    while (ndig < 8 && (v >> (4 * ndig)) != 0) begin
      ndig++;
    end
    for (int k = ndig - 1; k >= 0; k--) begin
      add_byte(hex_char(4'(v >> (4 * k)), lower));
    end
    if ($urandom_range(0, 4) == 0) begin
      add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    end
    if ($urandom_range(0, 3) == 0) begin
      add_byte(CH_SEMI);
      repeat ($urandom_range(0, 6)) add_byte(any_but_cr());
    end
    add_crlf();
  endtask

  // a restart, then chunks, the last chunk, trailers, end; or just random bytes
  task automatic gen_message();
    int unsigned len;
    int unsigned pos;
    int unsigned cut;
    restart_stream();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 24)) add_byte(8'($urandom));
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      add_size_line(len);
      repeat (len) add_byte(8'($urandom));
      add_crlf();
    end
    add_size_line(0);
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(1, 8)) add_byte(any_but_cr());
      add_crlf();
    end
    add_crlf();
    if ($urandom_range(0, 4) == 0) begin
      pos = $urandom_range(0, msg_q.size() - 1);
      case ($urandom_range(0, 3))
        0:       msg_q[pos] = 8'($urandom);
        1:       msg_q[pos] = CH_CR;
        2:       msg_q[pos] = CH_LF;
        default: msg_q.delete(pos);
      endcase
      // the parser stops at the fault, so little past it is worth sending
      cut = pos + $urandom_range(1, 4);
      while (msg_q.size() > cut) begin
        msg_q.delete(msg_q.size() - 1);
      end
    end
  endtask

  task automatic build_random(input int n);
    int start;
    start = stream_q.size();
    while (stream_q.size() + msg_q.size() < start + n) begin
      gen_message();
    end
    flush_msg();
  endtask

  task automatic build_directed();
    restart_stream();
    add_line(" a\t;ext=1");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CH_CR);
    add_byte(CH_LF);
    repeat (6) add_byte(8'($urandom));
    add_crlf();
    add_line("0");
    add_line("k:\tv");
    add_line("a\nb");
    add_crlf();
    add_byte("z");
    restart_stream();
    add_line("FfFfFfFf");
    add_byte(8'h80);
    add_byte(8'h01);
    restart_stream();
    add_line("00");
    add_crlf();
    restart_stream();
    add_text("100000000");
    restart_stream();
    add_text("1 2");
    restart_stream();
    add_line(";x");
    restart_stream();
    add_text("g");
    restart_stream();
    add_byte(CH_LF);
    restart_stream();
    add_line("1;a\nb");
    add_byte("p");
    add_byte(CH_CR);
    add_byte("x");
    restart_stream();
    add_line("1");
    add_byte("p");
    add_byte("x");
    restart_stream();
    add_text("1");
    add_byte(CH_CR);
    add_byte("x");
    restart_stream();
    add_line("0");
    add_text("ab");
    add_byte(CH_CR);
    add_byte("q");
    flush_msg();
  endtask

  // with both limits at 40: size line right at the limit, a trailer line at it,
  // then a trailer line one byte over it
  task automatic build_long_lines();
    restart_stream();
    repeat (39) add_byte(CH_SPACE);
    add_line("3");
    repeat (3) add_byte(8'($urandom));
    add_crlf();
    add_line("0");
    repeat (40) add_byte(any_but_cr());
    add_crlf();
    repeat (41) add_byte(any_but_cr());
    flush_msg();
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(input logic [CFG_W-1:0] size_max, input logic [CFG_W-1:0] trail_max);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MAX_SIZE_LINE;
    cfg_data  <= size_max;
    @(posedge clk_i);
    while (!cfg_ready) begin
      @(posedge clk_i);
    end
    cfg_index <= CFG_MAX_TRAIL_LINE;
    cfg_data  <= trail_max;
    @(posedge clk_i);
    while (!cfg_ready) begin
      @(posedge clk_i);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drive_stream(input int drain_at, input int hold_at);
    logic calm;
    calm = 1'b0;
    for (int i = 0; i < stream_q.size(); i++) begin
      if (i == hold_at) begin
        hold_req <= 1'b1;
      end
      if ($urandom_range(0, 40) == 0) begin
        calm = !calm;
      end
      if (i == drain_at) begin
        in_valid <= 1'b0;
        drain();
      end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      in_valid <= 1'b1;
      in_data  <= stream_q[i];
      @(posedge clk_i);
      while (!in_ready) begin
        @(posedge clk_i);
      end
    end
    in_valid <= 1'b0;
    stream_q.delete();
  endtask

  initial begin
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    build_directed();
    drive_stream(-1, -1);
    build_random(200);
    drive_stream(150, 40);
    drain();

    configure(14'd1, 14'd1);
    build_random(90);
    drive_stream(-1, -1);
    drain();

    configure(14'd5, 14'd7);
    build_random(140);
    drive_stream(80, -1);
    drain();

    configure(14'd40, 14'd40);
    build_long_lines();
    build_random(90);
    drive_stream(-1, -1);
    quiet <= 1'b1;
    drain();

    configure(14'd3, 14'd16383);
    build_random(110);
    drive_stream(-1, -1);
    drain();
    repeat (8) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("http_chunked_stream_decoder_top verification clean");
    end else begin
      $display("http_chunked_stream_decoder_top verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/hcsd_pkg.sv
rtl/core/hcsd_step.sv
rtl/core/http_chunked_stream_decoder_top.sv
bench/hcsd_decode_checker.sv
bench/http_chunked_stream_decoder_top_tb.sv
